FILE: hw/rtl/css_pkg.sv
// Package for the cursor sequence store: sizes, command and status codes,
// cell control word and sequencer states. No dependencies.
`timescale 1ns / 1ps

package css_pkg;

    localparam int DEPTH     = 64;
    localparam int WORD_BITS = 32;
    localparam int IDX_BITS  = $clog2(DEPTH);
    localparam int CNT_BITS  = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        CMD_START   = 3'd0,
        CMD_ADVANCE = 3'd1,
        CMD_INSERT  = 3'd2,
        CMD_ATTACH  = 3'd3,
        CMD_REMOVE  = 3'd4,
        CMD_READ    = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_NOCUR = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_REMOVE
    } t_cell_op;

    typedef struct packed {
        t_cell_op              op;
        logic [CNT_BITS-1:0]   pos;
        logic [WORD_BITS-1:0]  word;
    } t_cell_ctl;

    typedef enum logic {
        SQ_IDLE,
        SQ_SELECT
    } t_seq_state;

endpackage

FILE: hw/rtl/css_cell.sv
// One storage cell of the chain: holds one word, shifts with its neighbours
// on insert and remove, and drives its word onto the read and cursor buses.
// Depends on css_pkg.
`timescale 1ns / 1ps

module css_cell (
    input  logic                                 i_clk,
    input  logic [css_pkg::IDX_BITS-1:0]         i_idx,
    input  css_pkg::t_cell_ctl                   i_ctl,
    input  logic [css_pkg::WORD_BITS-1:0]        i_left,
    input  logic [css_pkg::WORD_BITS-1:0]        i_right,
    input  logic [css_pkg::CNT_BITS-1:0]         i_rd_pos,
    input  logic [css_pkg::CNT_BITS-1:0]         i_cur_pos,
    output logic [css_pkg::WORD_BITS-1:0]        o_word,
    output logic [css_pkg::WORD_BITS-1:0]        o_rd_word,
    output logic [css_pkg::WORD_BITS-1:0]        o_cur_word
);

    logic [css_pkg::WORD_BITS-1:0] r_word;
    logic [css_pkg::WORD_BITS-1:0] n_word;
    logic [css_pkg::CNT_BITS-1:0]  idx_ext;

    assign idx_ext = css_pkg::CNT_BITS'(i_idx);

    always_comb begin
        n_word = r_word;
        case (i_ctl.op)
            css_pkg::OP_INSERT: begin
                if (idx_ext == i_ctl.pos) begin
                    n_word = i_ctl.word;
                end else if (idx_ext > i_ctl.pos) begin
                    n_word = i_left;
                end
            end
            css_pkg::OP_REMOVE: begin
                if (idx_ext >= i_ctl.pos) begin
                    n_word = i_right;
                end
            end
            default: n_word = r_word;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word     = r_word;
    assign o_rd_word  = (idx_ext == i_rd_pos)  ? r_word : '0;
    assign o_cur_word = (idx_ext == i_cur_pos) ? r_word : '0;

endmodule

FILE: hw/rtl/cursor_sequence_store.sv
// Cursor sequence store: a chain of DEPTH word cells with a cursor.
// A command word is taken in the idle state and updates cells, count and cursor;
// the select state takes no new word and loads the result into the output register
// once that is free; a finished result may wait there while the next word is taken.
// Reset: i_rst_n clears item count, cursor, sequencer and output valid; cell
// contents are not reset. Depends on css_pkg and css_cell.
`timescale 1ns / 1ps

module cursor_sequence_store (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_cmd,
    input  logic [31:0] i_entry_value,
    input  logic [5:0]  i_read_index,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_read_value,
    output logic [31:0] o_current_value,
    output logic        o_has_current,
    output logic [6:0]  o_item_count,
    output logic [1:0]  o_status
);

    localparam int DEPTH     = css_pkg::DEPTH;
    localparam int WORD_BITS = css_pkg::WORD_BITS;
    localparam int CNT_BITS  = css_pkg::CNT_BITS;
    localparam int IDX_BITS  = css_pkg::IDX_BITS;

    css_pkg::t_seq_state r_state, n_state;
    logic [CNT_BITS-1:0] r_total, n_total;
    logic [CNT_BITS-1:0] r_cursor, n_cursor;
    logic [CNT_BITS-1:0] r_rd_pos, n_rd_pos;
    logic                r_rd_hit, n_rd_hit;
    css_pkg::t_status    r_cmd_status, n_cmd_status;

    logic                r_out_valid;
    logic [31:0]         r_read_value, r_current_value;
    logic                r_has_current;
    logic [6:0]          r_item_count;
    logic [1:0]          r_status;

    css_pkg::t_cell_ctl  cell_ctl;
    logic                accept;
    logic                load_out;
    logic                full;
    logic                cur_valid;
    logic [CNT_BITS-1:0] ins_pos;
    logic [CNT_BITS-1:0] rd_idx_ext;

    logic [WORD_BITS-1:0] cell_word [DEPTH];
    logic [WORD_BITS-1:0] rd_word   [DEPTH];
    logic [WORD_BITS-1:0] cur_word  [DEPTH];
    logic [WORD_BITS-1:0] rd_bus, cur_bus;
    logic                 sel_has_current;

    // cell chain
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [WORD_BITS-1:0] left_word, right_word;
        if (g == 0) begin : g_first
            assign left_word = '0;
        end else begin : g_mid_l
            assign left_word = cell_word[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign right_word = '0;
        end else begin : g_mid_r
            assign right_word = cell_word[g+1];
        end
        css_cell u_cell (
            .i_clk      (i_clk),
            .i_idx      (IDX_BITS'(g)),
            .i_ctl      (cell_ctl),
            .i_left     (left_word),
            .i_right    (right_word),
            .i_rd_pos   (r_rd_pos),
            .i_cur_pos  (r_cursor),
            .o_word     (cell_word[g]),
            .o_rd_word  (rd_word[g]),
            .o_cur_word (cur_word[g])
        );
    end

    always_comb begin
        rd_bus  = '0;
        cur_bus = '0;
        for (int i = 0; i < DEPTH; i++) begin
            rd_bus  = rd_bus | rd_word[i];
            cur_bus = cur_bus | cur_word[i];
        end
    end

    assign sel_has_current = r_cursor < r_total;

    // sequencer: next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            css_pkg::SQ_IDLE: begin
                if (i_valid) begin
                    n_state = css_pkg::SQ_SELECT;
                end
            end
            css_pkg::SQ_SELECT: begin
                if (!r_out_valid || !i_stall) begin
                    n_state = css_pkg::SQ_IDLE;
                end
            end
            default: n_state = css_pkg::SQ_IDLE;
        endcase
    end

    // sequencer: outputs
    always_comb begin
        o_stall  = 1'b1;
        load_out = 1'b0;
        case (r_state)
            css_pkg::SQ_IDLE:   o_stall = 1'b0;
            css_pkg::SQ_SELECT: load_out = !r_out_valid || !i_stall;
            default: begin
                o_stall  = 1'b1;
                load_out = 1'b0;
            end
        endcase
    end

    assign accept     = i_valid && !o_stall;
    assign full       = r_total >= CNT_BITS'(DEPTH);
    assign cur_valid  = r_cursor < r_total;
    assign rd_idx_ext = CNT_BITS'(i_read_index);

    // command decode
    always_comb begin
        n_total      = r_total;
        n_cursor     = r_cursor;
        n_rd_pos     = r_rd_pos;
        n_rd_hit     = r_rd_hit;
        n_cmd_status = r_cmd_status;
        ins_pos      = '0;
        cell_ctl.op   = css_pkg::OP_HOLD;
        cell_ctl.pos  = r_cursor;
        cell_ctl.word = WORD_BITS'(i_entry_value);
        if (accept) begin
            n_rd_hit     = 1'b0;
            n_rd_pos     = rd_idx_ext;
            n_cmd_status = css_pkg::ST_OK;
            case (css_pkg::t_cmd'(i_cmd))
                css_pkg::CMD_START: n_cursor = '0;
                css_pkg::CMD_ADVANCE: begin
                    if (cur_valid) begin
                        n_cursor = r_cursor + 1'b1;
                    end else begin
                        n_cmd_status = css_pkg::ST_NOCUR;
                    end
                end
                css_pkg::CMD_INSERT, css_pkg::CMD_ATTACH: begin
                    if (full) begin
                        n_cmd_status = css_pkg::ST_FULL;
                    end else begin
                        if (i_cmd == css_pkg::CMD_INSERT) begin
                            ins_pos = cur_valid ? r_cursor : '0;
                        end else begin
                            ins_pos = cur_valid ? r_cursor + 1'b1 : r_total;
                        end
                        cell_ctl.op  = css_pkg::OP_INSERT;
                        cell_ctl.pos = ins_pos;
                        n_cursor     = ins_pos;
                        n_total      = r_total + 1'b1;
                    end
                end
                css_pkg::CMD_REMOVE: begin
                    if (cur_valid) begin
                        cell_ctl.op = css_pkg::OP_REMOVE;
                        n_total     = r_total - 1'b1;
                    end else begin
                        n_cmd_status = css_pkg::ST_NOCUR;
                    end
                end
                css_pkg::CMD_READ: begin
                    if (rd_idx_ext < r_total) begin
                        n_rd_hit = 1'b1;
                    end else begin
                        n_cmd_status = css_pkg::ST_RANGE;
                    end
                end
                default: n_cmd_status = css_pkg::ST_OK;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= css_pkg::SQ_IDLE;
            r_total      <= '0;
            r_cursor     <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_total  <= n_total;
            r_cursor <= n_cursor;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_pos     <= n_rd_pos;
        r_rd_hit     <= n_rd_hit;
        r_cmd_status <= n_cmd_status;
        if (load_out) begin
            r_read_value    <= r_rd_hit ? 32'(rd_bus) : '0;
            r_current_value <= sel_has_current ? 32'(cur_bus) : '0;
            r_has_current   <= sel_has_current;
            r_item_count    <= 7'(r_total);
            r_status        <= r_cmd_status;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_read_value    = r_read_value;
    assign o_current_value = r_current_value;
    assign o_has_current   = r_has_current;
    assign o_item_count    = r_item_count;
    assign o_status        = r_status;

endmodule

FILE: bench/cursor_sequence_store_checker.sv
// Checker for cursor_sequence_store: watches both word channels, keeps its own
// copy of the store and cursor, and compares each result word field by field.
// Depends on css_pkg.
`timescale 1ns / 1ps

module cursor_sequence_store_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [2:0]  i_cmd,
    input  logic [31:0] i_entry_value,
    input  logic [5:0]  i_read_index,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [31:0] i_read_value,
    input  logic [31:0] i_current_value,
    input  logic        i_has_current,
    input  logic [6:0]  i_item_count,
    input  logic [1:0]  i_status,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked,
    output int          o_full_seen,
    output int          o_nocur_seen,
    output int          o_range_seen
);

    typedef struct packed {
        logic [31:0] read_value;
        logic [31:0] current_value;
        logic        has_current;
        logic [6:0]  item_count;
        logic [1:0]  status;
    } t_outcome;

    logic [css_pkg::WORD_BITS-1:0] store_words [css_pkg::DEPTH];
    int                            stored_count;
    int                            cursor_at;
    t_outcome                      outcomes_due [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
        o_full_seen  = 0;
        o_nocur_seen = 0;
        o_range_seen = 0;
        stored_count = 0;
        cursor_at    = 0;
    end

    function automatic t_outcome run_command(input logic [2:0] cmd,
                                             input logic [31:0] word,
                                             input logic [5:0] idx);
        t_outcome    res;
        logic [1:0]  st;
        logic [31:0] rd;
        int          i;
        st = css_pkg::ST_OK;
        rd = '0;
        case (cmd)
            css_pkg::CMD_START: begin
                cursor_at = 0;
            end
            css_pkg::CMD_ADVANCE: begin
                if (cursor_at < stored_count) cursor_at++;
                else st = css_pkg::ST_NOCUR;
            end
            css_pkg::CMD_INSERT: begin
                if (stored_count >= css_pkg::DEPTH) begin
                    st = css_pkg::ST_FULL;
                end else begin
                    if (cursor_at >= stored_count) cursor_at = 0;
                    for (i = stored_count; i > cursor_at; i--)
                        store_words[i] = store_words[i-1];
                    store_words[cursor_at] = word;
                    stored_count++;
                end
            end
            css_pkg::CMD_ATTACH: begin
                if (stored_count >= css_pkg::DEPTH) begin
                    st = css_pkg::ST_FULL;
                end else begin
                    if (cursor_at < stored_count) begin
                        for (i = stored_count; i > cursor_at + 1; i--)
                            store_words[i] = store_words[i-1];
                        cursor_at++;
                    end else begin
                        cursor_at = stored_count;
                    end
                    store_words[cursor_at] = word;
                    stored_count++;
                end
            end
            css_pkg::CMD_REMOVE: begin
                if (cursor_at < stored_count) begin
                    for (i = cursor_at; i + 1 < stored_count; i++)
                        store_words[i] = store_words[i+1];
                    stored_count--;
                end else begin
                    st = css_pkg::ST_NOCUR;
                end
            end
            css_pkg::CMD_READ: begin
                if (idx < stored_count) rd = store_words[idx];
                else st = css_pkg::ST_RANGE;
            end
            default: ;
        endcase
        res.read_value = rd;
        if (cursor_at < stored_count) begin
            res.current_value = store_words[cursor_at];
            res.has_current   = 1'b1;
        end else begin
            res.current_value = '0;
            res.has_current   = 1'b0;
        end
        res.item_count = 7'(stored_count);
        res.status     = st;
        return res;
    endfunction

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] seen);
        if (want !== seen) begin
            $display("%0t ns: %s mismatch, expected %h, got %h", $time, what, want, seen);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_outcome want;
        if (!i_rst_n) begin
            stored_count = 0;
            cursor_at    = 0;
            outcomes_due.delete();
        end else begin
            // result first: it belongs to an older command word
            if (i_out_valid && !i_out_stall) begin
                if (outcomes_due.size() == 0) begin
                    $display("%0t ns: unexpected result word, expected none, got %h %h %b %0d %0d",
                             $time, i_read_value, i_current_value, i_has_current,
                             i_item_count, i_status);
                    o_fail_count++;
                end else begin
                    want = outcomes_due.pop_front();
                    check_field("read_value", want.read_value, i_read_value);
                    check_field("current_value", want.current_value, i_current_value);
                    check_field("has_current", 32'(want.has_current), 32'(i_has_current));
                    check_field("item_count", 32'(want.item_count), 32'(i_item_count));
                    check_field("status", 32'(want.status), 32'(i_status));
                    o_checked++;
                end
            end
            if (i_in_valid && !i_in_stall) begin
                want = run_command(i_cmd, i_entry_value, i_read_index);
                case (want.status)
                    css_pkg::ST_FULL:  o_full_seen++;
                    css_pkg::ST_NOCUR: o_nocur_seen++;
                    css_pkg::ST_RANGE: o_range_seen++;
                    default: ;
                endcase
                outcomes_due.push_back(want);
            end
        end
        o_pending = outcomes_due.size();
    end

endmodule

FILE: bench/cursor_sequence_store_tb.sv
// Testbench top for cursor_sequence_store: clock, reset, directed and random
// command words, receiver stalls and the verdict. Depends on css_pkg, the block
// and cursor_sequence_store_checker.
`timescale 1ns / 1ps

module cursor_sequence_store_tb;

    localparam logic [2:0] CMD_SPARE_6  = 3'd6;
    localparam logic [2:0] CMD_SPARE_7  = 3'd7;
    localparam int         RANDOM_WORDS = 1600;
    localparam int         CYCLE_LIMIT  = 200000;
    localparam int         HOLD_CYCLES  = 60;

    typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} t_mix;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [2:0]  i_cmd;
    logic [31:0] i_entry_value;
    logic [5:0]  i_read_index;
    logic        o_valid;
    logic        i_stall;
    logic [31:0] o_read_value;
    logic [31:0] o_current_value;
    logic        o_has_current;
    logic [6:0]  o_item_count;
    logic [1:0]  o_status;

    int fail_count;
    int pending_count;
    int checked_count;
    int full_seen;
    int nocur_seen;
    int range_seen;
    int sent_count;
    bit no_idle;
    bit hold_request;
    bit hold_done;
    int hold_left;

    cursor_sequence_store DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_cmd           (i_cmd),
        .i_entry_value   (i_entry_value),
        .i_read_index    (i_read_index),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_read_value    (o_read_value),
        .o_current_value (o_current_value),
        .o_has_current   (o_has_current),
        .o_item_count    (o_item_count),
        .o_status        (o_status)
    );

    cursor_sequence_store_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_stall      (o_stall),
        .i_cmd           (i_cmd),
        .i_entry_value   (i_entry_value),
        .i_read_index    (i_read_index),
        .i_out_valid     (o_valid),
        .i_out_stall     (i_stall),
        .i_read_value    (o_read_value),
        .i_current_value (o_current_value),
        .i_has_current   (o_has_current),
        .i_item_count    (o_item_count),
        .i_status        (o_status),
        .o_fail_count    (fail_count),
        .o_pending       (pending_count),
        .o_checked       (checked_count),
        .o_full_seen     (full_seen),
        .o_nocur_seen    (nocur_seen),
        .o_range_seen    (range_seen)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    function automatic logic [2:0] pick_cmd(input t_mix mix);
        int r;
        int t_ins, t_att, t_rem, t_rd, t_adv;
        case (mix)
            MIX_FILL:  begin t_ins = 40; t_att = 75; t_rem = 80; t_rd = 88; t_adv = 94; end
            MIX_DRAIN: begin t_ins = 10; t_att = 17; t_rem = 60; t_rd = 75; t_adv = 88; end
            default:   begin t_ins = 25; t_att = 45; t_rem = 65; t_rd = 82; t_adv = 92; end
        endcase
        r = $urandom_range(0, 99);
        if (r < 3) return ($urandom_range(0, 1) != 0) ? CMD_SPARE_7 : CMD_SPARE_6;
        if (r < t_ins) return css_pkg::CMD_INSERT;
        if (r < t_att) return css_pkg::CMD_ATTACH;
        if (r < t_rem) return css_pkg::CMD_REMOVE;
        if (r < t_rd) return css_pkg::CMD_READ;
        if (r < t_adv) return css_pkg::CMD_ADVANCE;
        return css_pkg::CMD_START;
    endfunction

    function automatic logic [31:0] pick_word();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0) return 32'h0000_0000;
        if (r == 1) return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_word(input logic [2:0] c, input logic [31:0] w, input logic [5:0] x);
        while (!no_idle && $urandom_range(0, 99) < 8) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_cmd         <= c;
        i_entry_value <= w;
        i_read_index  <= x;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sent_count++;
        @(negedge i_clk);
    endtask

    // receiver side, including the one long hold-off
    initial begin
        i_stall   = 1'b0;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else begin
                i_stall <= !no_idle && ($urandom_range(0, 99) < 8);
            end
        end
    end

    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Run timed out after %0d cycles", cycles);
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        t_mix mix;
        int   seg_left;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_cmd         = css_pkg::CMD_START;
        i_entry_value = '0;
        i_read_index  = '0;
        no_idle       = 1'b0;
        hold_request  = 1'b0;
        sent_count    = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty store: range and no-current errors
        send_word(css_pkg::CMD_READ, 32'h0000_0000, 6'd0);
        send_word(css_pkg::CMD_ADVANCE, 32'h0000_0000, 6'd63);
        send_word(css_pkg::CMD_REMOVE, 32'hFFFF_FFFF, 6'd0);
        // insert with no current goes to the front
        send_word(css_pkg::CMD_INSERT, 32'hFFFF_FFFF, 6'd63);
        send_word(css_pkg::CMD_ATTACH, 32'h0000_0000, 6'd0);
        send_word(css_pkg::CMD_ADVANCE, 32'h1234_5678, 6'd0);
        // attach with no current appends at the end
        send_word(css_pkg::CMD_ATTACH, 32'hA5A5_A5A5, 6'd1);
        send_word(css_pkg::CMD_START, 32'h0000_0000, 6'd0);
        send_word(css_pkg::CMD_INSERT, 32'h5A5A_5A5A, 6'd0);
        send_word(css_pkg::CMD_READ, 32'h0000_0000, 6'd2);
        send_word(css_pkg::CMD_READ, 32'hFFFF_FFFF, 6'd63);
        send_word(css_pkg::CMD_ADVANCE, 32'h0000_0000, 6'd0);
        send_word(css_pkg::CMD_REMOVE, 32'h0000_0000, 6'd0);
        send_word(CMD_SPARE_6, 32'hDEAD_BEEF, 6'd21);
        send_word(CMD_SPARE_7, 32'hFFFF_FFFF, 6'd63);
        send_word(css_pkg::CMD_READ, 32'h0000_0000, 6'd0);
        send_word(css_pkg::CMD_START, 32'h0000_0000, 6'd42);
        send_word(css_pkg::CMD_REMOVE, 32'h0000_0000, 6'd0);
        send_word(css_pkg::CMD_REMOVE, 32'h0000_0000, 6'd0);
        send_word(css_pkg::CMD_REMOVE, 32'h0000_0000, 6'd0);
        send_word(css_pkg::CMD_REMOVE, 32'h0000_0000, 6'd0);
        send_word(css_pkg::CMD_INSERT, 32'h0000_0001, 6'd0);
        send_word(css_pkg::CMD_READ, 32'h0000_0000, 6'd1);

        mix      = MIX_FILL;
        seg_left = 200;
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            no_idle = (n >= 100 && n < 400);
            if (n == 120) hold_request = 1'b1;
            if (seg_left == 0) begin
                mix      = t_mix'($urandom_range(0, 2));
                seg_left = $urandom_range(60, 160);
            end
            seg_left--;
            send_word(pick_cmd(mix), pick_word(), 6'($urandom_range(0, 63)));
        end
        i_valid <= 1'b0;

        while (pending_count != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);

        $display("Covered %0d command words, %0d result words checked.",
                 sent_count, checked_count);
        $display("Errors exercised: store full %0d, no current item %0d, bad index %0d.",
                 full_seen, nocur_seen, range_seen);
        if (fail_count == 0 && pending_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
